### rtl/tws_pkg.sv
// Shared types, codes and frame helpers for the three-wire synthesizer programmer.
// No dependencies; used by tws_engine and three_wire_synth_programmer_unit.
package tws_pkg;

    localparam int unsigned FRAME_BITS = 25;
    localparam int unsigned CMD_BITS   = 5;
    localparam int unsigned DATA_BITS  = 20;
    localparam int unsigned ADDR_BITS  = 4;
    localparam int unsigned FREQ_BITS  = 14;
    localparam int unsigned INDEX_BITS = 5;

    localparam logic [DATA_BITS-1:0] REF_WORD_RESET = 20'd400;

    // Item kinds.
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_WRITE   = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;
    localparam logic [1:0] KIND_CHANNEL = 2'd3;

    // Fixed register addresses used by the set-channel sequence.
    localparam logic [ADDR_BITS-1:0] ADDR_REF_DIV  = 4'd0;
    localparam logic [ADDR_BITS-1:0] ADDR_CHAN_DIV = 4'd1;

    typedef struct packed {
        logic [1:0]           kind;
        logic [ADDR_BITS-1:0] reg_address;
        logic [DATA_BITS-1:0] write_data;
        logic [FREQ_BITS-1:0] freq_mhz;
        logic                 line_in;
    } item_t;

    typedef struct packed {
        logic                 latch_n;
        logic                 serial_clock;
        logic                 line_out;
        logic                 line_drive;
        logic                 busy_res;
        logic                 accepted;
        logic                 read_valid;
        logic [DATA_BITS-1:0] read_word;
    } result_t;

    typedef struct packed {
        logic busy;
        logic pending;
    } status_t;

    // Write frame: address, write bit set, then the data word, sent LSB first.
    function automatic logic [FRAME_BITS-1:0] write_frame(
        input logic [ADDR_BITS-1:0] addr,
        input logic [DATA_BITS-1:0] data
    );
        write_frame = {data, 1'b1, addr};
    endfunction

    // Channel word: t = f*25, then the upper bits of t moved up by one place
    // with a zero inserted above the low six bits.
    function automatic logic [DATA_BITS-1:0] channel_word(
        input logic [FREQ_BITS-1:0] freq
    );
        logic [18:0] t;
        t = 19'(freq) * 19'd25;
        channel_word = {t[18:6], 1'b0, t[5:0]};
    endfunction

endpackage

### rtl/tws_engine.sv
// Frame sequencer state and single-step update logic for the serial link.
// Depends on tws_pkg.
module tws_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  tws_pkg::item_t                item,
    input  logic [tws_pkg::DATA_BITS-1:0] ref_word,
    output tws_pkg::result_t              res,
    output tws_pkg::status_t              status
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WRITE,
        MODE_READ,
        MODE_GAP
    } mode_t;

    mode_t                              mode_reg, mode_next;
    logic                               phase_reg, phase_next;
    logic [tws_pkg::INDEX_BITS-1:0]     bit_index_reg, bit_index_next;
    logic [tws_pkg::FRAME_BITS-1:0]     out_shift_reg, out_shift_next;
    logic [tws_pkg::DATA_BITS-1:0]      in_shift_reg, in_shift_next;
    logic                               pending_reg, pending_next;
    logic [tws_pkg::DATA_BITS-1:0]      second_data_reg, second_data_next;

    always_comb
    begin
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        out_shift_next   = out_shift_reg;
        in_shift_next    = in_shift_reg;
        pending_next     = pending_reg;
        second_data_next = second_data_reg;
        res              = '0;

        if (item.kind != tws_pkg::KIND_TICK) begin
            if (mode_reg == MODE_IDLE) begin
                res.accepted   = 1'b1;
                phase_next     = 1'b0;
                bit_index_next = '0;
                in_shift_next  = '0;
                case (item.kind)
                    tws_pkg::KIND_WRITE:
                    begin
                        mode_next      = MODE_WRITE;
                        out_shift_next = tws_pkg::write_frame(item.reg_address,
                                                              item.write_data);
                    end
                    tws_pkg::KIND_READ:
                    begin
                        mode_next      = MODE_READ;
                        out_shift_next = tws_pkg::FRAME_BITS'(item.reg_address);
                    end
                    default:
                    begin
                        mode_next        = MODE_WRITE;
                        second_data_next = tws_pkg::channel_word(item.freq_mhz);
                        pending_next     = 1'b1;
                        out_shift_next   = tws_pkg::write_frame(tws_pkg::ADDR_REF_DIV,
                                                                ref_word);
                    end
                endcase
            end
        end else begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    mode_next = MODE_IDLE;
                end
                MODE_GAP:
                begin
                    pending_next   = 1'b0;
                    mode_next      = MODE_WRITE;
                    out_shift_next = tws_pkg::write_frame(tws_pkg::ADDR_CHAN_DIV,
                                                          second_data_reg);
                    phase_next     = 1'b0;
                    bit_index_next = '0;
                    in_shift_next  = '0;
                end
                default:
                begin
                    if (!phase_reg) begin
                        phase_next = 1'b1;
                    end else begin
                        // Falling edge: sample when reading, then move to the next bit.
                        phase_next     = 1'b0;
                        out_shift_next = out_shift_reg >> 1;
                        if (mode_reg == MODE_READ &&
                            bit_index_reg >= tws_pkg::INDEX_BITS'(tws_pkg::CMD_BITS)) begin
                            in_shift_next = {item.line_in, in_shift_reg[tws_pkg::DATA_BITS-1:1]};
                        end
                        if (bit_index_reg == tws_pkg::INDEX_BITS'(tws_pkg::FRAME_BITS - 1)) begin
                            if (mode_reg == MODE_READ) begin
                                res.read_valid = 1'b1;
                                res.read_word  = in_shift_next;
                            end
                            bit_index_next = '0;
                            mode_next      = pending_reg ? MODE_GAP : MODE_IDLE;
                        end else begin
                            bit_index_next = bit_index_reg + 1'b1;
                        end
                    end
                end
            endcase
        end

        if (mode_next == MODE_WRITE || mode_next == MODE_READ) begin
            res.latch_n      = 1'b0;
            res.serial_clock = phase_next;
            if (mode_next == MODE_READ &&
                bit_index_next >= tws_pkg::INDEX_BITS'(tws_pkg::CMD_BITS)) begin
                res.line_drive = 1'b0;
                res.line_out   = 1'b0;
            end else begin
                res.line_drive = 1'b1;
                res.line_out   = out_shift_next[0];
            end
        end else begin
            res.latch_n      = 1'b1;
            res.serial_clock = 1'b0;
            res.line_out     = 1'b0;
            res.line_drive   = 1'b1;
        end
        res.busy_res = (mode_next != MODE_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg        <= MODE_IDLE;
            phase_reg       <= 1'b0;
            bit_index_reg   <= '0;
            out_shift_reg   <= '0;
            in_shift_reg    <= '0;
            pending_reg     <= 1'b0;
            second_data_reg <= '0;
        end else if (advance) begin
            mode_reg        <= mode_next;
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            out_shift_reg   <= out_shift_next;
            in_shift_reg    <= in_shift_next;
            pending_reg     <= pending_next;
            second_data_reg <= second_data_next;
        end
    end

    assign status.busy     = (mode_reg != MODE_IDLE);
    assign status.pending  = pending_reg;

endmodule

### rtl/three_wire_synth_programmer_unit.sv
// Three-wire synthesizer programmer: an accepted input beat passes through the input register,
// then the result register, to its result beat on the output, and one beat is taken
// in every cycle while the output is not stalled. The single update step of the frame
// sequencer lies between the two registers; a stalled output holds the input.
// Reset (rst_n, asynchronous, active low) empties both stages, returns the link to idle
// and loads the reference divider word with its default of 400.
module three_wire_synth_programmer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [tws_pkg::DATA_BITS-1:0] cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [tws_pkg::ADDR_BITS-1:0] reg_address,
    input  logic [tws_pkg::DATA_BITS-1:0] write_data,
    input  logic [tws_pkg::FREQ_BITS-1:0] freq_mhz,
    input  logic                          line_in,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          latch_n,
    output logic                          serial_clock,
    output logic                          line_out,
    output logic                          line_drive,
    output logic                          busy_res,
    output logic                          accepted,
    output logic                          read_valid,
    output logic [tws_pkg::DATA_BITS-1:0] read_word
);

    // Reference divider word, sent to register 0 ahead of every channel frame.
    logic [tws_pkg::DATA_BITS-1:0] ref_word_reg;

    // Input stage: one beat held until the sequencer can step on it.
    logic             in_valid_reg;
    tws_pkg::item_t   item_reg;

    // Result stage.
    logic             out_valid_reg;
    tws_pkg::result_t res_reg;

    tws_pkg::result_t res_next;
    tws_pkg::status_t status;
    logic             advance;

    // The sequencer steps when a beat is held and the result register is free
    // or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ref_word_reg <= tws_pkg::REF_WORD_RESET;
        end else if (cfg_write) begin
            ref_word_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            item_reg.kind        <= kind;
            item_reg.reg_address <= reg_address;
            item_reg.write_data  <= write_data;
            item_reg.freq_mhz    <= freq_mhz;
            item_reg.line_in     <= line_in;
        end
    end

    tws_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (item_reg),
        .ref_word (ref_word_reg),
        .res      (res_next),
        .status   (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign latch_n      = res_reg.latch_n;
    assign serial_clock = res_reg.serial_clock;
    assign line_out     = res_reg.line_out;
    assign line_drive   = res_reg.line_drive;
    assign busy_res     = res_reg.busy_res;
    assign accepted     = res_reg.accepted;
    assign read_valid   = res_reg.read_valid;
    assign read_word    = res_reg.read_word;

`ifndef SYNTHESIS
    // A second frame may only be pending while the sequencer is busy.
    a_pending_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.pending |-> status.busy)
        else $error("pending second frame while sequencer idle");

    // A completed read leaves the link idle with the data line driven again.
    a_read_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.read_valid) |-> (res_reg.latch_n && res_reg.line_drive))
        else $error("read completion without returning the link to idle");

    // The data line is released only inside a frame.
    a_release_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.line_drive) |-> !res_reg.latch_n)
        else $error("data line released outside a frame");

    // A request is taken only when the sequencer was idle before the step.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.accepted) |-> !status.busy)
        else $error("request accepted while busy");
`endif

endmodule

### verif/tb_top.sv
// Self-checking bench for three_wire_synth_programmer_unit: drives request and tick beats,
// predicts the serial pin levels per beat, and compares every output beat.
// Depends on tws_pkg (item kinds, field widths, fixed register addresses).
`timescale 1ns / 100ps

module tb_top;

    // The bench tracks the link sequencer in its own terms: idle, sending a write frame,
    // running a read frame, or waiting one gap tick before the second channel frame.
    typedef enum logic [1:0] {LINK_IDLE, LINK_WRITE, LINK_READ, LINK_GAP} link_mode_t;

    localparam int unsigned STUCK_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [tws_pkg::DATA_BITS-1:0] cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    kind;
    logic [tws_pkg::ADDR_BITS-1:0] reg_address;
    logic [tws_pkg::DATA_BITS-1:0] write_data;
    logic [tws_pkg::FREQ_BITS-1:0] freq_mhz;
    logic                          line_in;
    logic                          out_valid;
    logic                          out_stall;
    logic                          latch_n;
    logic                          serial_clock;
    logic                          line_out;
    logic                          line_drive;
    logic                          busy_res;
    logic                          accepted;
    logic                          read_valid;
    logic [tws_pkg::DATA_BITS-1:0] read_word;

    // Once set, neither side idles any more; the last phase runs at full rate.
    bit quiet_tail;

    // Scoreboard: a private copy of the link sequencer. take_item() advances it by one
    // accepted input beat and queues the pin levels that beat must produce; check_pins()
    // compares an output beat with the oldest queued entry.
    class link_scoreboard;
        link_mode_t                     mode;
        bit                             phase;
        int unsigned                    bit_pos;
        logic [tws_pkg::FRAME_BITS-1:0] tx_frame;
        logic [tws_pkg::DATA_BITS-1:0]  rx_word;
        bit                             chan_pending;
        logic [tws_pkg::DATA_BITS-1:0]  chan_word;
        logic [tws_pkg::DATA_BITS-1:0]  ref_word;
        tws_pkg::result_t               expected_pins[$];
        int unsigned                    errors;

        function new();
            mode = LINK_IDLE;
            phase = 1'b0;
            bit_pos = 0;
            tx_frame = '0;
            rx_word = '0;
            chan_pending = 1'b0;
            chan_word = '0;
            ref_word = tws_pkg::REF_WORD_RESET;
            errors = 0;
        endfunction

        function void begin_frame(link_mode_t m, logic [tws_pkg::FRAME_BITS-1:0] frame);
            mode = m;
            tx_frame = frame;
            phase = 1'b0;
            bit_pos = 0;
            rx_word = '0;
        endfunction

        function void take_item(tws_pkg::item_t it);
            tws_pkg::result_t              r;
            logic [tws_pkg::DATA_BITS-1:0] prod;
            r = '0;
            if (it.kind != tws_pkg::KIND_TICK) begin
                // Requests only start a frame from idle; while busy they are dropped.
                if (mode == LINK_IDLE) begin
                    r.accepted = 1'b1;
                    if (it.kind == tws_pkg::KIND_WRITE)
                        begin_frame(LINK_WRITE, {it.write_data, 1'b1, it.reg_address});
                    else if (it.kind == tws_pkg::KIND_READ)
                        begin_frame(LINK_READ,
                                    {{tws_pkg::DATA_BITS{1'b0}}, 1'b0, it.reg_address});
                    else begin
                        prod = tws_pkg::DATA_BITS'(it.freq_mhz) * 20'd25;
                        chan_word = ((prod >> 6) << 7) | (prod & 20'd63);
                        chan_pending = 1'b1;
                        begin_frame(LINK_WRITE, {ref_word, 1'b1, tws_pkg::ADDR_REF_DIV});
                    end
                end
            end else if (mode == LINK_GAP) begin
                chan_pending = 1'b0;
                begin_frame(LINK_WRITE, {chan_word, 1'b1, tws_pkg::ADDR_CHAN_DIV});
            end else if (mode != LINK_IDLE) begin
                if (!phase)
                    phase = 1'b1;
                else begin
                    // Falling half: sample the line in the data part of a read, next bit.
                    phase = 1'b0;
                    if (mode == LINK_READ && bit_pos >= tws_pkg::CMD_BITS &&
                        bit_pos < tws_pkg::FRAME_BITS)
                        rx_word[bit_pos - tws_pkg::CMD_BITS] = it.line_in;
                    bit_pos++;
                    if (bit_pos >= tws_pkg::FRAME_BITS) begin
                        if (mode == LINK_READ) begin
                            r.read_valid = 1'b1;
                            r.read_word = rx_word;
                        end
                        bit_pos = 0;
                        mode = chan_pending ? LINK_GAP : LINK_IDLE;
                    end
                end
            end

            r.busy_res = (mode != LINK_IDLE);
            if (mode == LINK_WRITE || mode == LINK_READ) begin
                r.latch_n = 1'b0;
                r.serial_clock = phase;
                if (mode == LINK_READ && bit_pos >= tws_pkg::CMD_BITS) begin
                    r.line_drive = 1'b0;
                    r.line_out = 1'b0;
                end else begin
                    r.line_drive = 1'b1;
                    r.line_out = (bit_pos < tws_pkg::FRAME_BITS) ? tx_frame[bit_pos] : 1'b0;
                end
            end else begin
                r.latch_n = 1'b1;
                r.serial_clock = 1'b0;
                r.line_out = 1'b0;
                r.line_drive = 1'b1;
            end
            expected_pins.push_back(r);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_pins(tws_pkg::result_t got);
            tws_pkg::result_t want;
            if (expected_pins.size() == 0) begin
                $error("output beat with no expectation waiting");
                errors++;
                return;
            end
            want = expected_pins.pop_front();
            compare_field("latch_n", want.latch_n, got.latch_n);
            compare_field("serial_clock", want.serial_clock, got.serial_clock);
            compare_field("line_out", want.line_out, got.line_out);
            compare_field("line_drive", want.line_drive, got.line_drive);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("read_valid", want.read_valid, got.read_valid);
            compare_field("read_word", want.read_word, got.read_word);
        endfunction
    endclass

    link_scoreboard sb = new();

    three_wire_synth_programmer_unit u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .reg_address  (reg_address),
        .write_data   (write_data),
        .freq_mhz     (freq_mhz),
        .line_in      (line_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .latch_n      (latch_n),
        .serial_clock (serial_clock),
        .line_out     (line_out),
        .line_drive   (line_drive),
        .busy_res     (busy_res),
        .accepted     (accepted),
        .read_valid   (read_valid),
        .read_word    (read_word)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Both handshakes are sampled at the rising edge, before any register in the block
    // or any bench driver has updated, so the order of processes in the step is irrelevant.
    always @(posedge clk)
    begin
        tws_pkg::item_t   seen;
        tws_pkg::result_t pins;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                seen.kind = kind;
                seen.reg_address = reg_address;
                seen.write_data = write_data;
                seen.freq_mhz = freq_mhz;
                seen.line_in = line_in;
                sb.take_item(seen);
            end
            if (out_valid && !out_stall) begin
                pins.latch_n = latch_n;
                pins.serial_clock = serial_clock;
                pins.line_out = line_out;
                pins.line_drive = line_drive;
                pins.busy_res = busy_res;
                pins.accepted = accepted;
                pins.read_valid = read_valid;
                pins.read_word = read_word;
                sb.check_pins(pins);
            end
        end
    end

    // Output back-pressure: occasional stall bursts, none in the tail.
    initial
    begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && !quiet_tail && $urandom_range(0, 9) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    initial
    begin
        int unsigned stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // Presents one input beat and returns at the edge where it is taken. Valid stays high
    // afterwards so back-to-back beats never lower and raise it in the same step.
    task automatic send_item(input logic [1:0] k, input logic [tws_pkg::ADDR_BITS-1:0] a,
                             input logic [tws_pkg::DATA_BITS-1:0] d,
                             input logic [tws_pkg::FREQ_BITS-1:0] f,
                             input logic l);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        kind <= k;
        reg_address <= a;
        write_data <= d;
        freq_mhz <= f;
        line_in <= l;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // Tick beats carry random values in the fields the block ignores on a tick.
    task automatic send_tick(input logic l);
        send_item(tws_pkg::KIND_TICK, tws_pkg::ADDR_BITS'($urandom),
                  tws_pkg::DATA_BITS'($urandom), tws_pkg::FREQ_BITS'($urandom), l);
    endtask

    // Runs n ticks. line_mode 0 holds the line low, 1 holds it high, 2 randomizes it.
    // With strays set, a random request is sometimes slipped in; the busy block drops it.
    task automatic run_ticks(input int unsigned n, input int unsigned line_mode,
                             input bit strays);
        logic l;
        for (int unsigned i = 0; i < n; i++) begin
            if (strays && $urandom_range(0, 15) == 0)
                send_item(2'($urandom_range(1, 3)), tws_pkg::ADDR_BITS'($urandom),
                          tws_pkg::DATA_BITS'($urandom), tws_pkg::FREQ_BITS'($urandom),
                          1'($urandom));
            l = (line_mode == 2) ? 1'($urandom) : (line_mode == 1);
            send_tick(l);
        end
    endtask

    // Register writes happen only with nothing in flight and the link idle. The first
    // edge lets the monitor note the last beat taken before the queue is looked at.
    task automatic set_ref_word(input logic [tws_pkg::DATA_BITS-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_pins.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_data <= value;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.ref_word = value;
    endtask

    // One complete random frame: request, every tick it needs, maybe a stray idle tick.
    // Returns the number of beats that moved the link.
    task automatic random_frame(output int unsigned moved);
        logic [1:0]                    k;
        logic [tws_pkg::DATA_BITS-1:0] d;
        logic [tws_pkg::FREQ_BITS-1:0] f;
        int unsigned                   pick;
        pick = $urandom_range(0, 19);
        k = (pick < 8) ? tws_pkg::KIND_WRITE :
            (pick < 15) ? tws_pkg::KIND_READ : tws_pkg::KIND_CHANNEL;
        case ($urandom_range(0, 7))
            0:       d = '0;
            1:       d = '1;
            default: d = tws_pkg::DATA_BITS'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       f = '0;
            1:       f = '1;
            default: f = tws_pkg::FREQ_BITS'($urandom);
        endcase
        send_item(k, tws_pkg::ADDR_BITS'($urandom), d, f, 1'($urandom));
        // A channel request is two 50-tick frames with a single gap tick between them.
        run_ticks((k == tws_pkg::KIND_CHANNEL) ? 101 : 50, 2, 1'b1);
        moved = (k == tws_pkg::KIND_CHANNEL) ? 102 : 51;
        if ($urandom_range(0, 3) == 0)
            send_tick(1'($urandom));
    endtask

    initial
    begin
        int unsigned moved;
        int unsigned phase_beats;
        quiet_tail = 1'b0;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        kind <= tws_pkg::KIND_TICK;
        reg_address <= '0;
        write_data <= '0;
        freq_mhz <= '0;
        line_in <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A tick while idle does nothing.
        send_tick(1'b1);
        // Write with every address and data bit set; requests during the frame are dropped.
        send_item(tws_pkg::KIND_WRITE, '1, '1, '0, 1'b1);
        send_item(tws_pkg::KIND_READ, '0, '0, '1, 1'b0);
        send_item(tws_pkg::KIND_CHANNEL, '1, '0, '1, 1'b1);
        send_item(tws_pkg::KIND_WRITE, '0, '1, '0, 1'b0);
        run_ticks(50, 1, 1'b0);
        // Read with a toggling line.
        send_item(tws_pkg::KIND_READ, 4'h5, '0, '0, 1'b1);
        run_ticks(50, 2, 1'b0);
        // Channel frames: reset divider word first, then the all-ones register value.
        send_item(tws_pkg::KIND_CHANNEL, '0, '0, '1, 1'b0);
        run_ticks(101, 2, 1'b1);
        set_ref_word('1);
        send_item(tws_pkg::KIND_CHANNEL, '1, '1, '0, 1'b1);
        run_ticks(101, 2, 1'b0);

        // Random part in two phases, each under a new divider word; the last at full rate.
        for (int unsigned ph = 0; ph < 2; ph++) begin
            if (ph == 1)
                quiet_tail = 1'b1;
            set_ref_word(tws_pkg::DATA_BITS'($urandom));
            phase_beats = 0;
            while (phase_beats < 40) begin
                random_frame(moved);
                phase_beats += moved;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_pins.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.expected_pins.size() != 0)
            $error("%0d expected output beats never arrived", sb.expected_pins.size());
        if (sb.errors == 0 && sb.expected_pins.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
